FILE: design/linear_probe_hash_table_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the linear probe hash table.
// Every macro expects signals named clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPHT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LPHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/lpht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared widths, operation and status codes and the slot layout of the
// linear probe hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int KEY_W          = 16;
  localparam int WORD_W         = 16;
  localparam int FUNC_W         = 2;
  localparam int STAT_W         = 2;
  localparam int TABLE_SIZE_DEF = 101;

  // Operation codes carried by the func field.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_SEARCH = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_DELETE = 2'd2
  } func_t;

  // Result status codes.
  localparam logic [STAT_W-1:0] RES_OK      = 2'd0;
  localparam logic [STAT_W-1:0] RES_MISSING = 2'd1;
  localparam logic [STAT_W-1:0] RES_FULL    = 2'd2;

  // Slot tags kept in memory.
  localparam logic [1:0] SLOT_EMPTY   = 2'd0;
  localparam logic [1:0] SLOT_USED    = 2'd1;
  localparam logic [1:0] SLOT_DELETED = 2'd2;

  // One table slot: tag, key and the two data words (first word lowest).
  typedef struct packed {
    logic [1:0]        tag;
    logic [KEY_W-1:0]  key;
    logic [WORD_W-1:0] second;
    logic [WORD_W-1:0] first;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

endpackage

FILE: design/lpht_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_if
// Valid/ready channels of the hash table: the request word and the
// result word.
// ----------------------------------------------------------------------------
interface lpht_in_if;
  import lpht_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [KEY_W-1:0]  lookup_key;
  logic [WORD_W-1:0] word_first;
  logic [WORD_W-1:0] word_second;

  modport source (output valid, func, lookup_key, word_first, word_second, input ready);
  modport sink   (input valid, func, lookup_key, word_first, word_second, output ready);
endinterface

interface lpht_out_if;
  import lpht_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [WORD_W-1:0] found_first;
  logic [WORD_W-1:0] found_second;

  modport source (output valid, status, found_first, found_second, input ready);
  modport sink   (input valid, status, found_first, found_second, output ready);
endinterface

FILE: design/lpht_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/lpht_home.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_home
// Home slot unit: key mod TABLE_SIZE by multiplication with a reciprocal,
// in two registered stages followed by one compare and subtract.
// ----------------------------------------------------------------------------
module lpht_home #(
  parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [lpht_pkg::KEY_W-1:0]    key,
  output logic                          home_valid,
  output logic [$clog2(TABLE_SIZE)-1:0] home_idx
);
  import lpht_pkg::*;

  localparam int IDX_W   = $clog2(TABLE_SIZE);
  localparam int SHIFT   = KEY_W + IDX_W;
  localparam int RECIP_W = KEY_W + 2;
  localparam int PROD_W  = KEY_W + RECIP_W;
  localparam longint unsigned RECIP_L = (64'd1 << SHIFT) / TABLE_SIZE;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

  logic              v1_r, v2_r;
  logic [PROD_W-1:0] prod_r;
  logic [KEY_W-1:0]  key1_r, key2_r;
  logic [KEY_W-1:0]  qt_r;
  logic [KEY_W-1:0]  quot;
  logic [KEY_W-1:0]  diff;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
    end
  end

  // Stage one: key times the scaled reciprocal.
  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= PROD_W'(key) * PROD_W'(RECIP);
      key1_r <= key;
    end
  end

  // Stage two: quotient estimate times the table size. The estimate is at
  // most one below the true quotient, so the product never exceeds the key.
  assign quot = KEY_W'(prod_r >> SHIFT);

  always_ff @(posedge clk) begin
    if (v1_r) begin
      qt_r   <= KEY_W'(32'(quot) * 32'(TABLE_SIZE));
      key2_r <= key1_r;
    end
  end

  // The remainder estimate is below twice the table size; one correction.
  assign diff       = key2_r - qt_r;
  assign home_valid = v2_r;
  assign home_idx   = (diff >= KEY_W'(TABLE_SIZE)) ? IDX_W'(diff - KEY_W'(TABLE_SIZE))
                                                   : IDX_W'(diff);

endmodule

FILE: design/linear_probe_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing hash table with linear probing. Slots live in one RAM;
// each operation walks its probe chain one slot per cycle.
// ----------------------------------------------------------------------------
//
//  Port     Dir  Word contents
//  in_word  in   func, lookup_key, word_first, word_second
//  out_word out  status, found_first, found_second
//
// An operation that visits between 1 and TABLE_SIZE slots passes from acceptance
// through the home slot unit (whose result issues the first RAM read), then the
// slot reads on the single RAM port, one per probed slot, then back to idle. After
// reset a clearing pass marks every slot empty; no request is taken during it. A
// result held by a stalled sink blocks only the completion of the next operation,
// not its acceptance.
//
module linear_probe_hash_table #(
  parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  lpht_in_if.sink     in_word,
  lpht_out_if.source  out_word
);
  import lpht_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_HASH  = 5'b00100,
    S_CHECK = 5'b01000,
    S_SPARE = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic [FUNC_W-1:0] func_r;
  logic [KEY_W-1:0]  key_r;
  logic [WORD_W-1:0] first_r, second_r;

  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [WORD_W-1:0] out_first_r, out_second_r;

  logic              in_fire;
  logic              out_free;
  logic              home_valid;
  logic [IDX_W-1:0]  home_idx;

  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  slot_t             ram_wdata;
  logic [SLOT_W-1:0] ram_rdata;
  slot_t             rd;

  logic              res_load;
  logic [STAT_W-1:0] res_status;
  logic [WORD_W-1:0] res_first, res_second;
  logic              probe_done, probe_write;
  slot_t             probe_wdata;
  logic              is_used, is_empty, is_match, is_last;

  assign in_fire        = in_word.valid && in_word.ready;
  assign in_word.ready  = (state_r == S_IDLE);
  assign out_free       = !out_valid_r || out_word.ready;
  assign rd             = slot_t'(ram_rdata);

  // Home slot unit.
  lpht_home #(.TABLE_SIZE(TABLE_SIZE)) u_home (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_fire),
    .key        (in_word.lookup_key),
    .home_valid (home_valid),
    .home_idx   (home_idx)
  );

  // Slot memory.
  lpht_ram #(.WIDTH(SLOT_W), .DEPTH(TABLE_SIZE)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Decision on the slot just read.
  assign is_used  = (rd.tag == SLOT_USED);
  assign is_empty = (rd.tag == SLOT_EMPTY);
  assign is_match = is_used && (rd.key == key_r);
  assign is_last  = (cnt_r == LAST_IDX);

  always_comb begin
    probe_done  = 1'b0;
    probe_write = 1'b0;
    probe_wdata = rd;
    res_status  = RES_MISSING;
    res_first   = '0;
    res_second  = '0;
    unique case (func_t'(func_r))
      FUNC_SEARCH, FUNC_DELETE: begin
        if (is_match) begin
          probe_done  = 1'b1;
          res_status  = RES_OK;
          res_first   = rd.first;
          res_second  = rd.second;
          probe_write = (func_t'(func_r) == FUNC_DELETE);
          probe_wdata.tag = SLOT_DELETED;
        end else if (is_empty || is_last) begin
          probe_done = 1'b1;
        end
      end
      FUNC_INSERT: begin
        if (!is_used) begin
          probe_done  = 1'b1;
          probe_write = 1'b1;
          res_status  = RES_OK;
          probe_wdata = '{tag: SLOT_USED, key: key_r, second: second_r, first: first_r};
        end else if (is_last) begin
          probe_done = 1'b1;
          res_status = RES_FULL;
        end
      end
      default: begin
        probe_done = 1'b1;
      end
    endcase
  end

  // Sequencer: clearing pass, home slot wait and the probe walk.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = probe_wdata;
    ram_re    = 1'b0;
    ram_raddr = idx_r;
    res_load  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '{tag: SLOT_EMPTY, default: '0};
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (home_valid) begin
          ram_re    = 1'b1;
          ram_raddr = home_idx;
          idx_nxt   = home_idx;
          cnt_nxt   = '0;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (probe_done) begin
          // Finish only when the result register can take the word.
          if (out_free) begin
            res_load  = 1'b1;
            ram_we    = probe_write;
            state_nxt = S_IDLE;
          end
        end else begin
          idx_nxt   = (idx_r == LAST_IDX) ? '0 : idx_r + IDX_W'(1);
          cnt_nxt   = cnt_r + IDX_W'(1);
          ram_re    = 1'b1;
          ram_raddr = idx_nxt;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      idx_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r   <= in_word.func;
      key_r    <= in_word.lookup_key;
      first_r  <= in_word.word_first;
      second_r <= in_word.word_second;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_word.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_status_r <= res_status;
      out_first_r  <= res_first;
      out_second_r <= res_second;
    end
  end

  assign out_word.valid        = out_valid_r;
  assign out_word.status       = out_status_r;
  assign out_word.found_first  = out_first_r;
  assign out_word.found_second = out_second_r;

endmodule

FILE: design/lpht_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_checker
// Port-level checks of the hash table, bound to the top level.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_table_macros.svh"

module lpht_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [lpht_pkg::STAT_W-1:0]   out_status,
  input logic [lpht_pkg::WORD_W-1:0]   out_found_first,
  input logic [lpht_pkg::WORD_W-1:0]   out_found_second
);
  import lpht_pkg::*;

  logic              miss_out;
  logic [WORD_W-1:0] words_or;

  // A miss or a full table is any offered word that is not a success.
  assign miss_out = out_valid && (out_status != RES_OK);
  assign words_or = out_found_first | out_found_second;

  // A held result word stays offered.
  `LPHT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result word dropped")

  // Only the three defined status codes leave the block.
  `LPHT_ASSERT_IMP(a_status_code, out_valid, out_status <= RES_FULL, "undefined status code")

  // A miss or a full table carries zero data words.
  `LPHT_ASSERT_IMP(a_miss_zero, miss_out, words_or == '0, "nonzero words on a miss")

  // One operation at a time: an accepted request makes the block busy.
  `LPHT_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "request taken while busy")

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_word.valid),
  .in_ready         (in_word.ready),
  .out_valid        (out_word.valid),
  .out_ready        (out_word.ready),
  .out_status       (out_word.status),
  .out_found_first  (out_word.found_first),
  .out_found_second (out_word.found_second)
);

FILE: bench/lpht_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_tb_pkg
// Scoreboard for the linear probe hash table bench. It keeps a shadow copy
// of the slot table, predicts the result word of every accepted request and
// checks each result word the block returns against the oldest prediction.
// ----------------------------------------------------------------------------
package lpht_tb_pkg;
  import lpht_pkg::*;

  // The block has no code for this operation; it must answer "missing".
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // One predicted result word.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [WORD_W-1:0] first;
    logic [WORD_W-1:0] second;
  } table_result_t;

  class hash_table_scoreboard;
    logic [1:0]        slot_tag    [TABLE_SIZE_DEF];
    logic [KEY_W-1:0]  slot_key    [TABLE_SIZE_DEF];
    logic [WORD_W-1:0] slot_first  [TABLE_SIZE_DEF];
    logic [WORD_W-1:0] slot_second [TABLE_SIZE_DEF];
    table_result_t     awaited_results[$];
    int                failures;

    function new();
      foreach (slot_tag[i]) slot_tag[i] = SLOT_EMPTY;
      failures = 0;
    endfunction

    // Walks the probe chain of key; returns the matching slot or -1.
    function int probe_for_key(logic [KEY_W-1:0] key);
      int idx;
      idx = int'(key) % TABLE_SIZE_DEF;
      for (int n = 0; n < TABLE_SIZE_DEF; n++) begin
        if (slot_tag[idx] == SLOT_EMPTY) return -1;
        if (slot_tag[idx] == SLOT_USED && slot_key[idx] == key) return idx;
        idx = (idx + 1) % TABLE_SIZE_DEF;
      end
      return -1;
    endfunction

    function int used_slots();
      int count;
      count = 0;
      foreach (slot_tag[i]) if (slot_tag[i] == SLOT_USED) count++;
      return count;
    endfunction

    function int outstanding();
      return awaited_results.size();
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    // Applies an accepted request to the shadow table and queues its result.
    function void note_request(logic [FUNC_W-1:0] func, logic [KEY_W-1:0] key,
                               logic [WORD_W-1:0] first, logic [WORD_W-1:0] second);
      table_result_t res;
      int            idx;
      res = '{status: RES_MISSING, first: '0, second: '0};
      case (func)
        FUNC_SEARCH, FUNC_DELETE: begin
          idx = probe_for_key(key);
          if (idx >= 0) begin
            res.status = RES_OK;
            res.first  = slot_first[idx];
            res.second = slot_second[idx];
            if (func == FUNC_DELETE) slot_tag[idx] = SLOT_DELETED;
          end
        end
        FUNC_INSERT: begin
          // The first slot that is not in use takes the entry.
          res.status = RES_FULL;
          idx = int'(key) % TABLE_SIZE_DEF;
          for (int n = 0; n < TABLE_SIZE_DEF; n++) begin
            if (slot_tag[idx] != SLOT_USED) begin
              slot_key[idx]    = key;
              slot_first[idx]  = first;
              slot_second[idx] = second;
              slot_tag[idx]    = SLOT_USED;
              res.status       = RES_OK;
              break;
            end
            idx = (idx + 1) % TABLE_SIZE_DEF;
          end
        end
        default: ;
      endcase
      awaited_results.push_back(res);
    endfunction

    // Compares one result word with the oldest prediction.
    function void check_result(logic [STAT_W-1:0] status, logic [WORD_W-1:0] first,
                               logic [WORD_W-1:0] second);
      table_result_t want;
      if (awaited_results.size() == 0) begin
        note_failure($sformatf("unexpected result: status %0d first %h second %h",
                               status, first, second));
        return;
      end
      want = awaited_results.pop_front();
      if (status !== want.status || first !== want.first || second !== want.second)
        note_failure($sformatf(
          "mismatch: expected status %0d first %h second %h, got status %0d first %h second %h",
          want.status, want.first, want.second, status, first, second));
    endfunction

    // Predictions still waiting at the end count as failures.
    function void close_out();
      if (awaited_results.size() != 0)
        note_failure($sformatf("%0d results never arrived", awaited_results.size()));
    endfunction
  endclass

endpackage

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the linear probe hash table. A directed sequence covers empty
// table, collisions, wrap-around, tombstones, duplicates and the unused
// operation; random phases then load the table to full and keep working on
// it with chains of colliding keys. The sender runs in bursts and the
// receiver stalls in changing patterns, including one long hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import lpht_pkg::*;
  import lpht_tb_pkg::*;

  typedef enum int {RX_STREAM, RX_MOSTLY_READY, RX_EVERY_THIRD, RX_MOSTLY_STALLED} rx_mode_t;

  localparam int POOL_N      = 24;
  localparam int HOLD_CYCLES = 300;

  logic clk;
  logic rst_n;

  lpht_in_if  in_ch ();
  lpht_out_if out_ch ();

  linear_probe_hash_table DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_ch),
    .out_word (out_ch)
  );

  hash_table_scoreboard table_sb;
  logic [KEY_W-1:0]     key_pool [POOL_N];
  int                   burst_left;
  bit                   no_gaps;
  bit                   hold_req;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  initial begin
    #5_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  // Offers one request word and returns at the falling edge after it is taken.
  task automatic send_req(logic [FUNC_W-1:0] fn, logic [KEY_W-1:0] key,
                          logic [WORD_W-1:0] w_first, logic [WORD_W-1:0] w_second);
    if (burst_left == 0) begin
      if (!no_gaps) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_ch.valid       <= 1'b1;
    in_ch.func        <= fn;
    in_ch.lookup_key  <= key;
    in_ch.word_first  <= w_first;
    in_ch.word_second <= w_second;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    table_sb.note_request(fn, key, w_first, w_second);
    burst_left--;
    @(negedge clk);
  endtask

  // Stops offering until every predicted result has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (table_sb.outstanding() != 0);
  endtask

  // Mostly keys that share a few home slots, so probe chains grow.
  function automatic logic [KEY_W-1:0] pick_key();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 75) return key_pool[$urandom_range(0, POOL_N - 1)];
    return KEY_W'($urandom);
  endfunction

  function automatic logic [FUNC_W-1:0] pick_func(int ins_pct, int del_pct);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 5) return FUNC_UNUSED;
    if (sel < 5 + ins_pct) return FUNC_INSERT;
    if (sel < 5 + ins_pct + del_pct) return FUNC_DELETE;
    return FUNC_SEARCH;
  endfunction

  task automatic send_random(int ins_pct, int del_pct);
    send_req(pick_func(ins_pct, del_pct), pick_key(), WORD_W'($urandom), WORD_W'($urandom));
  endtask

  // Receiver: changing stall patterns, plus one long hold-off on request.
  initial begin
    rx_mode_t mode;
    int       seg_left;
    int       rx_phase;
    bit       rdy;
    out_ch.ready = 1'b0;
    mode     = RX_STREAM;
    seg_left = 0;
    rx_phase = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode     = rx_mode_t'($urandom_range(0, 3));
          seg_left = $urandom_range(8, 80);
        end
        seg_left--;
        rx_phase = (rx_phase + 1) % 3;
        case (mode)
          RX_STREAM:         rdy = 1'b1;
          RX_MOSTLY_READY:   rdy = ($urandom_range(0, 99) < 75);
          RX_EVERY_THIRD:    rdy = (rx_phase == 0);
          RX_MOSTLY_STALLED: rdy = ($urandom_range(0, 99) < 25);
          default:           rdy = 1'b1;
        endcase
        out_ch.ready <= rdy;
      end
    end
  end

  // Result check at each accepted result word.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      table_sb.check_result(out_ch.status, out_ch.found_first, out_ch.found_second);
  end

  // Stimulus.
  initial begin
    int homes [3];
    int home;
    table_sb          = new();
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.func        = FUNC_SEARCH;
    in_ch.lookup_key  = '0;
    in_ch.word_first  = '0;
    in_ch.word_second = '0;
    burst_left        = 0;
    no_gaps           = 1'b0;
    hold_req          = 1'b0;

    // Keys sharing home slot 0, the last slot (wrap-around) and one random slot.
    homes[0] = 0;
    homes[1] = TABLE_SIZE_DEF - 1;
    homes[2] = $urandom_range(1, TABLE_SIZE_DEF - 2);
    for (int i = 0; i < POOL_N; i++) begin
      home = homes[i % 3];
      key_pool[i] = KEY_W'(home + TABLE_SIZE_DEF *
                           $urandom_range(0, (65535 - home) / TABLE_SIZE_DEF));
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, collisions, wrap-around, tombstones, duplicates.
    send_req(FUNC_SEARCH, 16'd0,     16'h0000, 16'h0000);
    send_req(FUNC_INSERT, 16'd0,     16'h0000, 16'h0000);
    send_req(FUNC_INSERT, 16'hFFFF,  16'hFFFF, 16'hFFFF);
    send_req(FUNC_INSERT, 16'd101,   16'hA5A5, 16'h5A5A);
    send_req(FUNC_INSERT, 16'd100,   16'h1234, 16'h5678);
    send_req(FUNC_INSERT, 16'd201,   16'h8001, 16'h7FFE);
    send_req(FUNC_SEARCH, 16'd201,   16'hFFFF, 16'hFFFF);
    send_req(FUNC_SEARCH, 16'd101,   16'h0000, 16'h0000);
    send_req(FUNC_DELETE, 16'd0,     16'h0000, 16'h0000);
    send_req(FUNC_SEARCH, 16'd101,   16'h0000, 16'h0000);
    send_req(FUNC_SEARCH, 16'd0,     16'h0000, 16'h0000);
    send_req(FUNC_INSERT, 16'd202,   16'hC3C3, 16'h3C3C);
    send_req(FUNC_SEARCH, 16'd202,   16'h0000, 16'h0000);
    send_req(FUNC_DELETE, 16'd7,     16'h0000, 16'h0000);
    send_req(FUNC_UNUSED, 16'hFFFF,  16'hFFFF, 16'hFFFF);
    send_req(FUNC_SEARCH, 16'hFFFF,  16'h0000, 16'h0000);
    send_req(FUNC_INSERT, 16'hFFFF,  16'h0001, 16'h8000);
    send_req(FUNC_SEARCH, 16'hFFFF,  16'h0000, 16'h0000);
    send_req(FUNC_DELETE, 16'hFFFF,  16'h0000, 16'h0000);
    send_req(FUNC_SEARCH, 16'hFFFF,  16'h0000, 16'h0000);
    send_req(FUNC_DELETE, 16'd202,   16'h0000, 16'h0000);
    send_req(FUNC_DELETE, 16'd101,   16'h0000, 16'h0000);
    send_req(FUNC_SEARCH, 16'd201,   16'h0000, 16'h0000);
    drain();

    // Random mix while the table is partly loaded; one long receiver hold-off.
    for (int i = 0; i < 200; i++) begin
      if (i == 60) begin
        hold_req = 1'b1;
        no_gaps  = 1'b1;
      end
      if (i == 80) no_gaps = 1'b0;
      send_random(40, 25);
    end

    // Load the table until every slot is in use, then work on the full table.
    while (table_sb.used_slots() < TABLE_SIZE_DEF)
      send_req(FUNC_INSERT, pick_key(), WORD_W'($urandom), WORD_W'($urandom));
    repeat (4) send_req(FUNC_INSERT, pick_key(), WORD_W'($urandom), WORD_W'($urandom));
    repeat (4) send_req(FUNC_SEARCH, KEY_W'($urandom), 16'h0000, 16'h0000);
    send_req(FUNC_DELETE, KEY_W'($urandom), 16'h0000, 16'h0000);
    drain();

    // Random mix on a table with no empty slots left, only tombstones.
    for (int i = 0; i < 200; i++) send_random(30, 35);
    drain();

    repeat (2 * TABLE_SIZE_DEF) @(negedge clk);
    table_sb.close_out();
    if (table_sb.failures == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/lpht_pkg.sv
design/lpht_if.sv
design/lpht_ram.sv
design/lpht_home.sv
design/linear_probe_hash_table.sv
design/lpht_checker.sv
bench/lpht_tb_pkg.sv
bench/tb_top.sv
